@@ src/rgbnpe_pkg.sv @@
// Shared types, constants and helper functions for the RGB node pattern engine.
// No dependencies; imported by rgbnpe_next, rgb_node_pattern_engine and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package rgbnpe_pkg;

	localparam int NodeCount  = 10;
	localparam int ChildCount = 6;
	localparam int NodeW      = 3;
	localparam int PatternW   = NodeCount * NodeW;

	localparam logic [NodeW-1:0] ColR = 3'h1;
	localparam logic [NodeW-1:0] ColG = 3'h2;
	localparam logic [NodeW-1:0] ColB = 3'h4;

	typedef logic [NodeW-1:0] colour_t;
	typedef logic [PatternW-1:0] pattern_t;

	typedef enum logic [3:0] {
		OP_SET_NODE    = 4'd0,
		OP_SET_MAIN    = 4'd1,
		OP_SET_CHILD   = 4'd2,
		OP_SET_ALL     = 4'd3,
		OP_ROTATE      = 4'd4,
		OP_FLOOD_LEFT  = 4'd5,
		OP_FLOOD_RIGHT = 4'd6,
		OP_FLOOD_LIFT  = 4'd7,
		OP_LIFT        = 4'd8
	} opcode_t;

	typedef enum logic [1:0] {
		SEED_RING = 2'd0,
		SEED_RGB  = 2'd1,
		SEED_PAIR = 2'd2,
		SEED_MIX  = 2'd3
	} seed_t;

	// One command as held in the input stage.
	typedef struct packed {
		logic [3:0] opcode;
		logic [3:0] node_index;
		colour_t    colour;
		logic       init;
		logic       direction;
		logic       auto_switch;
		logic [1:0] seed;
	} cmd_t;

	// Colour cycle R, G, B, RG, GB, BR, RGB, then R again; off goes to R.
	function automatic colour_t next_colour(input colour_t c);
		colour_t r;
		case (c)
			3'h0:    r = ColR;
			3'h1:    r = ColG;
			3'h2:    r = ColB;
			3'h3:    r = ColG | ColB;
			3'h4:    r = ColR | ColG;
			3'h5:    r = ColR | ColG | ColB;
			3'h6:    r = ColB | ColR;
			default: r = ColR;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/rgbnpe_next.sv @@
// Next-pattern logic: applies one command to the current node pattern.
// Depends on rgbnpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbnpe_next (
	input  wire  rgbnpe_pkg::cmd_t     cmd,
	input  wire  rgbnpe_pkg::pattern_t cur_pattern,
	output rgbnpe_pkg::pattern_t       nxt_pattern
);
	import rgbnpe_pkg::*;

	colour_t old_n [NodeCount];
	colour_t new_n [NodeCount];
	colour_t fill;

	always_comb begin
		for (int n = 0; n < NodeCount; n++) begin
			old_n[n] = cur_pattern[n*NodeW +: NodeW];
		end
	end

	always_comb begin
		for (int n = 0; n < NodeCount; n++) begin
			new_n[n] = old_n[n];
		end
		fill = '0;
		case (cmd.opcode)
			OP_SET_NODE: begin
				if (cmd.node_index < 4'(NodeCount)) begin
					new_n[cmd.node_index] = cmd.colour;
				end
			end
			OP_SET_MAIN: begin
				for (int n = ChildCount; n < NodeCount; n++) new_n[n] = cmd.colour;
			end
			OP_SET_CHILD: begin
				for (int n = 0; n < ChildCount; n++) new_n[n] = cmd.colour;
			end
			OP_SET_ALL: begin
				for (int n = 0; n < NodeCount; n++) new_n[n] = cmd.colour;
			end
			OP_ROTATE: begin
				case (cmd.seed)
					SEED_RGB: begin
						new_n[0] = ColR; new_n[1] = ColG; new_n[2] = ColB;
						new_n[3] = ColR; new_n[4] = ColG; new_n[5] = ColB;
					end
					SEED_PAIR: begin
						new_n[0] = ColR | ColG; new_n[1] = ColG | ColB;
						new_n[2] = ColB | ColR; new_n[3] = ColR | ColG;
						new_n[4] = ColG | ColB; new_n[5] = ColB | ColR;
					end
					SEED_MIX: begin
						new_n[0] = ColR | ColB; new_n[1] = ColG | ColR;
						new_n[2] = ColB | ColG; new_n[3] = ColR | ColB;
						new_n[4] = ColG | ColR; new_n[5] = ColB | ColG;
					end
					default: begin
						for (int n = 0; n < ChildCount; n++) begin
							if (cmd.direction) begin
								new_n[n] = old_n[(n + 1) % ChildCount];
							end else begin
								new_n[n] = old_n[(n + ChildCount - 1) % ChildCount];
							end
						end
					end
				endcase
			end
			OP_FLOOD_LEFT: begin
				if (cmd.init) begin
					for (int n = 1; n < ChildCount; n++) new_n[n] = '0;
					new_n[0] = cmd.colour;
				end else if (cmd.auto_switch && old_n[ChildCount-1] == old_n[0]) begin
					new_n[0] = next_colour(old_n[0]);
				end else begin
					for (int n = 1; n < ChildCount; n++) new_n[n] = old_n[n-1];
				end
			end
			OP_FLOOD_RIGHT: begin
				if (cmd.init) begin
					for (int n = 0; n < ChildCount - 1; n++) new_n[n] = '0;
					new_n[ChildCount-1] = cmd.colour;
				end else if (cmd.auto_switch && old_n[ChildCount-1] == old_n[0]) begin
					new_n[ChildCount-1] = next_colour(old_n[0]);
				end else begin
					for (int n = 0; n < ChildCount - 1; n++) new_n[n] = old_n[n+1];
				end
			end
			OP_FLOOD_LIFT: begin
				if (cmd.init) begin
					for (int n = ChildCount; n < NodeCount; n++) new_n[n] = '0;
					if (cmd.direction) begin
						new_n[ChildCount] = cmd.colour;
					end else begin
						new_n[NodeCount-1] = cmd.colour;
					end
				end else begin
					if (cmd.auto_switch && old_n[NodeCount-1] == old_n[ChildCount]) begin
						fill = next_colour(old_n[ChildCount]);
					end else if (cmd.direction) begin
						fill = old_n[ChildCount];
					end else begin
						fill = old_n[NodeCount-1];
					end
					if (cmd.direction) begin
						for (int n = ChildCount + 1; n < NodeCount; n++) new_n[n] = old_n[n-1];
						new_n[ChildCount] = fill;
					end else begin
						for (int n = ChildCount; n < NodeCount - 1; n++) new_n[n] = old_n[n+1];
						new_n[NodeCount-1] = fill;
					end
				end
			end
			OP_LIFT: begin
				// Main nodes scroll with a period of three: the end node takes
				// the colour that left the opposite end two steps earlier.
				if (cmd.init) begin
					new_n[6] = ColR; new_n[7] = ColG; new_n[8] = ColB; new_n[9] = ColR;
				end else if (cmd.direction) begin
					new_n[6] = old_n[7]; new_n[7] = old_n[8];
					new_n[8] = old_n[9]; new_n[9] = old_n[7];
				end else begin
					new_n[7] = old_n[6]; new_n[8] = old_n[7];
					new_n[9] = old_n[8]; new_n[6] = old_n[8];
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int n = 0; n < NodeCount; n++) begin
			nxt_pattern[n*NodeW +: NodeW] = new_n[n];
		end
	end

endmodule

`default_nettype wire

@@ src/rgb_node_pattern_engine.sv @@
// Top level of the RGB node pattern engine: input stage, pattern register, handshakes.
// Depends on rgbnpe_pkg and rgbnpe_next.
`timescale 1ns / 1ps
`default_nettype none

// The engine holds ten 3-bit RGB nodes (children 0-5, main 6-9) and returns the
// whole 30-bit pattern after every command, one result per command. A command
// is captured in an input register and moves into the pattern register once the
// output slot is free or being taken; a new command can be taken every cycle
// while out_ready does not stall the output. The pattern register doubles as the
// output register; while a result waits on out_ready, one more command can be
// held in the input stage. Reset clears every node to off.

module rgb_node_pattern_engine (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [3:0] opcode,
	input  wire  [3:0] node_index,
	input  wire  [2:0] colour,
	input  wire        init,
	input  wire        direction,
	input  wire        auto_switch,
	input  wire  [1:0] seed,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [29:0] led_pattern
);
	import rgbnpe_pkg::*;

	cmd_t     cmd_s1;
	logic     valid_s1;
	pattern_t pattern_q;
	logic     out_valid_q;
	pattern_t nxt_pattern;
	logic     advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	rgbnpe_next u_next (
		.cmd         (cmd_s1),
		.cur_pattern (pattern_q),
		.nxt_pattern (nxt_pattern)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= '{opcode: opcode, node_index: node_index, colour: colour,
				init: init, direction: direction, auto_switch: auto_switch,
				seed: seed};
		end
	end

	// The pattern only changes when a command moves into the output slot, so
	// the waiting result stays stable until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pattern_q <= nxt_pattern;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign led_pattern = pattern_q;

endmodule

`default_nettype wire

@@ sim/rgb_node_pattern_engine_tb.sv @@
// Self-checking testbench for rgb_node_pattern_engine: directed and random commands,
// idle and stall phases, a long output hold-off. Depends on rgbnpe_pkg and the RTL in src.
`timescale 1ns / 1ps

module rgb_node_pattern_engine_tb;
	import rgbnpe_pkg::*;

	localparam int WatchdogLimit = 4000;
	localparam int DrainCycles   = 8;
	localparam int HoldCycles    = 300;
	localparam int ReportLimit   = 10;
	localparam logic [3:0] OP_UNUSED_TOP = 4'hF;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  opcode;
	logic [3:0]  node_index;
	logic [2:0]  colour;
	logic        init;
	logic        direction;
	logic        auto_switch;
	logic [1:0]  seed;
	logic        out_valid;
	logic        out_ready;
	logic [29:0] led_pattern;

	pattern_t shadow_pattern;
	pattern_t pending_patterns[$];
	int       mismatches;
	int       send_idle_pct;
	int       recv_stall_pct;
	int       hold_left;
	int       quiet_cycles;
	int       items_done;

	rgb_node_pattern_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.node_index(node_index),
		.colour(colour),
		.init(init),
		.direction(direction),
		.auto_switch(auto_switch),
		.seed(seed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.led_pattern(led_pattern)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Colour cycle: R, G, B, RG, GB, BR, RGB, back to R; off also goes to R.
	function automatic colour_t colour_after(colour_t c);
		case (c)
			ColR:                return ColG;
			ColG:                return ColB;
			ColB:                return colour_t'(ColR | ColG);
			colour_t'(ColR | ColG): return colour_t'(ColG | ColB);
			colour_t'(ColG | ColB): return colour_t'(ColB | ColR);
			colour_t'(ColB | ColR): return colour_t'(ColR | ColG | ColB);
			default:             return ColR;
		endcase
	endfunction

	function automatic pattern_t next_pattern(pattern_t pat, cmd_t c);
		colour_t nd[NodeCount];
		colour_t od[NodeCount];
		colour_t fill;
		pattern_t res;
		int i;
		for (i = 0; i < NodeCount; i++) nd[i] = pat[NodeW*i +: NodeW];
		od = nd;
		case (c.opcode)
			OP_SET_NODE: begin
				if (c.node_index < NodeCount) nd[c.node_index] = c.colour;
			end
			OP_SET_MAIN: for (i = ChildCount; i < NodeCount; i++) nd[i] = c.colour;
			OP_SET_CHILD: for (i = 0; i < ChildCount; i++) nd[i] = c.colour;
			OP_SET_ALL: for (i = 0; i < NodeCount; i++) nd[i] = c.colour;
			OP_ROTATE: begin
				case (c.seed)
					SEED_RGB: for (i = 0; i < ChildCount; i++)
						nd[i] = (i % 3 == 0) ? ColR : (i % 3 == 1) ? ColG : ColB;
					SEED_PAIR: for (i = 0; i < ChildCount; i++)
						nd[i] = (i % 3 == 0) ? colour_t'(ColR | ColG) :
							(i % 3 == 1) ? colour_t'(ColG | ColB) : colour_t'(ColB | ColR);
					SEED_MIX: for (i = 0; i < ChildCount; i++)
						nd[i] = (i % 3 == 0) ? colour_t'(ColR | ColB) :
							(i % 3 == 1) ? colour_t'(ColG | ColR) : colour_t'(ColB | ColG);
					default: begin
						for (i = 0; i < ChildCount; i++)
							nd[i] = c.direction ? od[(i + 1) % ChildCount]
								: od[(i + ChildCount - 1) % ChildCount];
					end
				endcase
			end
			OP_FLOOD_LEFT: begin
				if (c.init) begin
					for (i = 0; i < ChildCount; i++) nd[i] = '0;
					nd[0] = c.colour;
				end else if (c.auto_switch && od[5] == od[0]) begin
					nd[0] = colour_after(od[0]);
				end else begin
					for (i = 1; i < ChildCount; i++) nd[i] = od[i-1];
				end
			end
			OP_FLOOD_RIGHT: begin
				if (c.init) begin
					for (i = 0; i < ChildCount; i++) nd[i] = '0;
					nd[5] = c.colour;
				end else if (c.auto_switch && od[5] == od[0]) begin
					nd[5] = colour_after(od[0]);
				end else begin
					for (i = 0; i < ChildCount - 1; i++) nd[i] = od[i+1];
				end
			end
			OP_FLOOD_LIFT: begin
				if (c.init) begin
					for (i = ChildCount; i < NodeCount; i++) nd[i] = '0;
					if (c.direction) nd[6] = c.colour;
					else nd[9] = c.colour;
				end else begin
					if (c.auto_switch && od[9] == od[6]) fill = colour_after(od[6]);
					else fill = c.direction ? od[6] : od[9];
					if (c.direction) begin
						for (i = 7; i < NodeCount; i++) nd[i] = od[i-1];
						nd[6] = fill;
					end else begin
						for (i = 6; i < NodeCount - 1; i++) nd[i] = od[i+1];
						nd[9] = fill;
					end
				end
			end
			OP_LIFT: begin
				if (c.init) begin
					nd[6] = ColR;
					nd[7] = ColG;
					nd[8] = ColB;
					nd[9] = ColR;
				end else if (c.direction) begin
					nd[6] = od[7];
					nd[7] = od[8];
					nd[8] = od[9];
					nd[9] = od[7];
				end else begin
					nd[7] = od[6];
					nd[8] = od[7];
					nd[9] = od[8];
					nd[6] = od[8];
				end
			end
			default: ;
		endcase
		for (i = 0; i < NodeCount; i++) res[NodeW*i +: NodeW] = nd[i];
		return res;
	endfunction

	function automatic bit is_ignored(cmd_t c);
		return (c.opcode > OP_LIFT) || (c.opcode == OP_SET_NODE && c.node_index >= NodeCount);
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		c.opcode      = ($urandom_range(99) < 88) ? 4'($urandom_range(OP_LIFT, 0))
			: 4'($urandom_range(OP_UNUSED_TOP, OP_LIFT + 1));
		c.node_index  = 4'($urandom_range(15, 0));
		c.colour      = colour_t'($urandom);
		c.init        = 1'($urandom);
		c.direction   = 1'($urandom);
		c.auto_switch = 1'($urandom);
		c.seed        = 2'($urandom);
		return c;
	endfunction

	// Holds valid and payload until the transaction is taken, then updates the model.
	task automatic send_cmd(cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= c.opcode;
		node_index  <= c.node_index;
		colour      <= c.colour;
		init        <= c.init;
		direction   <= c.direction;
		auto_switch <= c.auto_switch;
		seed        <= c.seed;
		do @(posedge clk); while (!in_ready);
		shadow_pattern = next_pattern(shadow_pattern, c);
		pending_patterns.push_back(shadow_pattern);
		if (!is_ignored(c)) items_done++;
	endtask

	task automatic issue(logic [3:0] op, logic [3:0] idx, colour_t col, logic ini,
			logic dir, logic aut, seed_t sd);
		cmd_t c;
		c.opcode      = op;
		c.node_index  = idx;
		c.colour      = col;
		c.init        = ini;
		c.direction   = dir;
		c.auto_switch = aut;
		c.seed        = sd;
		send_cmd(c);
	endtask

	task automatic test_set_commands();
		issue(OP_SET_ALL, 4'd0, 3'h7, 1'b1, 1'b1, 1'b1, SEED_MIX);
		issue(OP_SET_NODE, 4'd9, 3'h5, 1'b0, 1'b0, 1'b0, SEED_RING);
		issue(OP_SET_MAIN, 4'd15, 3'h2, 1'b0, 1'b1, 1'b0, SEED_RGB);
		issue(OP_SET_CHILD, 4'd0, 3'h4, 1'b1, 1'b0, 1'b1, SEED_PAIR);
	endtask

	task automatic test_ignored_commands();
		issue(OP_SET_NODE, 4'd10, 3'h7, 1'b0, 1'b0, 1'b0, SEED_RING);
		issue(OP_SET_NODE, 4'd15, 3'h0, 1'b1, 1'b1, 1'b1, SEED_MIX);
		issue(OP_UNUSED_TOP, 4'd15, 3'h7, 1'b1, 1'b1, 1'b1, SEED_MIX);
	endtask

	task automatic test_rotate();
		issue(OP_ROTATE, 4'd0, 3'h0, 1'b0, 1'b0, 1'b0, SEED_RGB);
		issue(OP_ROTATE, 4'd0, 3'h0, 1'b0, 1'b0, 1'b0, SEED_PAIR);
		issue(OP_ROTATE, 4'd0, 3'h0, 1'b0, 1'b0, 1'b0, SEED_MIX);
		issue(OP_ROTATE, 4'd0, 3'h0, 1'b0, 1'b1, 1'b0, SEED_RING);
		issue(OP_ROTATE, 4'd0, 3'h0, 1'b0, 1'b0, 1'b0, SEED_RING);
	endtask

	task automatic test_flood_children();
		// Equal end nodes with auto switch set make node 0 advance its colour.
		issue(OP_SET_CHILD, 4'd0, 3'h6, 1'b0, 1'b0, 1'b0, SEED_RING);
		issue(OP_FLOOD_LEFT, 4'd0, 3'h0, 1'b0, 1'b0, 1'b1, SEED_RING);
		issue(OP_FLOOD_LEFT, 4'd0, 3'h3, 1'b1, 1'b0, 1'b0, SEED_RING);
		issue(OP_FLOOD_LEFT, 4'd0, 3'h0, 1'b0, 1'b0, 1'b0, SEED_RING);
		issue(OP_FLOOD_RIGHT, 4'd0, 3'h7, 1'b1, 1'b0, 1'b0, SEED_RING);
		issue(OP_FLOOD_RIGHT, 4'd0, 3'h0, 1'b0, 1'b0, 1'b1, SEED_RING);
	endtask

	task automatic test_flood_lift();
		issue(OP_FLOOD_LIFT, 4'd0, 3'h5, 1'b1, 1'b1, 1'b0, SEED_RING);
		issue(OP_FLOOD_LIFT, 4'd0, 3'h0, 1'b0, 1'b1, 1'b1, SEED_RING);
		issue(OP_FLOOD_LIFT, 4'd0, 3'h0, 1'b1, 1'b0, 1'b0, SEED_RING);
		issue(OP_FLOOD_LIFT, 4'd0, 3'h0, 1'b0, 1'b0, 1'b1, SEED_RING);
	endtask

	task automatic test_lift();
		issue(OP_LIFT, 4'd0, 3'h0, 1'b1, 1'b0, 1'b0, SEED_RING);
		issue(OP_LIFT, 4'd0, 3'h0, 1'b0, 1'b1, 1'b0, SEED_RING);
		issue(OP_LIFT, 4'd0, 3'h0, 1'b0, 1'b0, 1'b0, SEED_RING);
	endtask

	// The output side is held off while commands keep coming, so the block fills up.
	task automatic test_backpressure();
		int k;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = HoldCycles;
		for (k = 0; k < 24; k++) send_cmd(random_cmd());
	endtask

	// Mostly seeded flood, lift and rotate runs with random content, plus loose commands.
	task automatic test_random(int count, int idle_pct, int stall_pct);
		cmd_t c;
		logic [3:0] op;
		logic dir;
		int len;
		int k;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		items_done     = 0;
		while (items_done < count) begin
			if ($urandom_range(9) < 4) begin
				send_cmd(random_cmd());
			end else begin
				case ($urandom_range(4))
					0:       op = OP_FLOOD_LEFT;
					1:       op = OP_FLOOD_RIGHT;
					2:       op = OP_FLOOD_LIFT;
					3:       op = OP_LIFT;
					default: op = OP_ROTATE;
				endcase
				dir = 1'($urandom);
				len = $urandom_range(14, 3);
				for (k = 0; k < len; k++) begin
					c = random_cmd();
					if ($urandom_range(9) != 0) begin
						c.opcode      = op;
						c.init        = (k == 0);
						c.direction   = ($urandom_range(9) == 0) ? ~dir : dir;
						c.auto_switch = ($urandom_range(9) < 7);
						if (op == OP_ROTATE)
							c.seed = (k == 0) ? 2'($urandom_range(SEED_MIX, SEED_RGB))
								: SEED_RING;
					end
					send_cmd(c);
				end
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		opcode         = '0;
		node_index     = '0;
		colour         = '0;
		init           = 1'b0;
		direction      = 1'b0;
		auto_switch    = 1'b0;
		seed           = '0;
		shadow_pattern = '0;
		mismatches     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 0;
		items_done     = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_set_commands();
		test_ignored_commands();
		test_rotate();
		test_flood_children();
		test_flood_lift();
		test_lift();
		test_backpressure();
		test_random(300, 0, 0);
		test_random(300, 58, 0);
		test_random(300, 0, 58);
		test_random(300, 23, 23);
		in_valid <= 1'b0;

		while (pending_patterns.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Output ready: random stalls, or a counted hold-off when one is requested.
	initial begin
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		pattern_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_patterns.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportLimit)
					$display("unexpected transaction: led_pattern %h", led_pattern);
			end else begin
				want = pending_patterns.pop_front();
				if (led_pattern !== want) begin
					mismatches++;
					if (mismatches <= ReportLimit)
						$display("led_pattern mismatch: expected %h, got %h", want, led_pattern);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("timeout: no transaction in %0d cycles", WatchdogLimit);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
